// ----- sv/gmsp_pkg.sv -----
// ----------------------------------------------------------------------------
// gmsp_pkg
// Types, codes and small helper functions shared by the GIF metadata parser.
// ----------------------------------------------------------------------------
`default_nettype none

package gmsp_pkg;

  localparam int MaxRecs = 7;
  localparam int CntW    = 3;

  localparam logic [7:0] ByteTrailer = 8'h3B;
  localparam logic [7:0] ByteExtIntr = 8'h21;
  localparam logic [7:0] ByteImgSep  = 8'h2C;
  localparam logic [7:0] LabelGce    = 8'hF9;
  localparam logic [7:0] LabelCmt    = 8'hFE;
  localparam logic [7:0] LabelApp    = 8'hFF;
  localparam logic [7:0] AppIdLen    = 8'd11;
  localparam logic [7:0] CharG       = 8'h47;
  localparam logic [7:0] CharI       = 8'h49;
  localparam logic [7:0] CharF       = 8'h46;

  typedef enum logic [3:0] {
    KindVersion = 4'd0,
    KindWidth   = 4'd1,
    KindHeight  = 4'd2,
    KindGctFlag = 4'd3,
    KindColorRes = 4'd4,
    KindSortFlag = 4'd5,
    KindGctSize = 4'd6,
    KindDelayMs = 4'd7,
    KindTranspIdx = 4'd8,
    KindCmtChar = 4'd9,
    KindAppChar = 4'd10,
    KindLoopCnt = 4'd11,
    KindNotGif  = 4'd12,
    KindEnd     = 4'd13
  } kind_e;

  typedef enum logic [4:0] {
    PhHdr      = 5'd0,
    PhLsd      = 5'd1,
    PhGct      = 5'd2,
    PhBlk      = 5'd3,
    PhImg      = 5'd4,
    PhLct      = 5'd5,
    PhLzw      = 5'd6,
    PhSubLen   = 5'd7,
    PhSubData  = 5'd8,
    PhExt      = 5'd9,
    PhGce      = 5'd10,
    PhCmtLen   = 5'd11,
    PhCmtData  = 5'd12,
    PhAppLen   = 5'd13,
    PhAppSkip  = 5'd14,
    PhAppId    = 5'd15,
    PhNets     = 5'd16,
    PhDoneEnd  = 5'd17,
    PhDoneOpen = 5'd18
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [19:0] value;
    logic        first;
  } rec_t;

  typedef struct packed {
    rec_t [MaxRecs-1:0] recs;
    logic [CntW-1:0]    cnt;
  } run_t;

  // color table length in bytes: 3 * 2^(k+1)
  function automatic logic [9:0] table_bytes(input logic [2:0] k);
    table_bytes = (10'd4 << k) + (10'd2 << k);
  endfunction

  function automatic logic [7:0] netscape_char(input logic [3:0] idx);
    case (idx)
      4'd0:    netscape_char = 8'h4E;
      4'd1:    netscape_char = 8'h45;
      4'd2:    netscape_char = 8'h54;
      4'd3:    netscape_char = 8'h53;
      4'd4:    netscape_char = 8'h43;
      4'd5:    netscape_char = 8'h41;
      4'd6:    netscape_char = 8'h50;
      4'd7:    netscape_char = 8'h45;
      4'd8:    netscape_char = 8'h32;
      4'd9:    netscape_char = 8'h2E;
      4'd10:   netscape_char = 8'h30;
      default: netscape_char = 8'h00;
    endcase
  endfunction

  function automatic rec_t mk_rec(input kind_e k, input logic [19:0] v, input logic f);
    rec_t r;
    r.kind  = k;
    r.value = v;
    r.first = f;
    mk_rec = r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/gmsp_parser.sv -----
// ----------------------------------------------------------------------------
// gmsp_parser
// Parse state registers and the per-beat step that builds the record run.
// ----------------------------------------------------------------------------
`default_nettype none

module gmsp_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          eoi_i,
  output gmsp_pkg::run_t     run_o
);

  gmsp_pkg::phase_e phase_q, phase_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [7:0]  sub_q, sub_d;
  logic [15:0] ver_q, ver_d;
  logic [7:0]  packed_q, packed_d;
  logic [7:0]  low_q, low_d;
  logic        appm_q, appm_d;
  logic        nul_q, nul_d;
  logic        started_q, started_d;
  logic        sigbad_q, sigbad_d;

  always_comb begin
    logic [9:0]  c;
    logic [3:0]  ci;
    logic [15:0] d;
    logic [19:0] dw;
    logic [gmsp_pkg::CntW-1:0] n;
    gmsp_pkg::run_t run;

    phase_d   = phase_q;
    cnt_d     = cnt_q;
    sub_d     = sub_q;
    ver_d     = ver_q;
    packed_d  = packed_q;
    low_d     = low_q;
    appm_d    = appm_q;
    nul_d     = nul_q;
    started_d = started_q;
    sigbad_d  = sigbad_q;
    c   = cnt_q;
    ci  = (cnt_q > 10'd10) ? 4'd10 : cnt_q[3:0];
    d   = {byte_i, low_q};
    dw  = ({4'b0, d} << 3) + ({4'b0, d} << 1);
    n   = '0;
    run = '0;

    case (phase_q)
      gmsp_pkg::PhHdr: begin
        if (c == 10'd0) sigbad_d = (byte_i != gmsp_pkg::CharG);
        else if (c == 10'd1) sigbad_d = sigbad_q || (byte_i != gmsp_pkg::CharI);
        else if (c == 10'd2) sigbad_d = sigbad_q || (byte_i != gmsp_pkg::CharF);
        else if (c == 10'd3) ver_d = {ver_q[15:8], byte_i};
        else if (c == 10'd4) ver_d = {byte_i, ver_q[7:0]};
        if (c >= 10'd5) begin
          if (sigbad_q) begin
            run.recs[n] = gmsp_pkg::mk_rec(gmsp_pkg::KindNotGif, 20'd0, 1'b0);
            n = n + 1'b1;
            phase_d = gmsp_pkg::PhDoneOpen;
          end else begin
            run.recs[0] = gmsp_pkg::mk_rec(gmsp_pkg::KindVersion,
                                           {12'd0, gmsp_pkg::CharG}, 1'b0);
            run.recs[1] = gmsp_pkg::mk_rec(gmsp_pkg::KindVersion,
                                           {12'd0, gmsp_pkg::CharI}, 1'b0);
            run.recs[2] = gmsp_pkg::mk_rec(gmsp_pkg::KindVersion,
                                           {12'd0, gmsp_pkg::CharF}, 1'b0);
            run.recs[3] = gmsp_pkg::mk_rec(gmsp_pkg::KindVersion,
                                           {12'd0, ver_q[7:0]}, 1'b0);
            run.recs[4] = gmsp_pkg::mk_rec(gmsp_pkg::KindVersion,
                                           {12'd0, ver_q[15:8]}, 1'b0);
            run.recs[5] = gmsp_pkg::mk_rec(gmsp_pkg::KindVersion,
                                           {12'd0, byte_i}, 1'b0);
            n = 3'd6;
            phase_d = gmsp_pkg::PhLsd;
          end
          cnt_d = '0;
        end else begin
          cnt_d = c + 10'd1;
        end
      end
      gmsp_pkg::PhLsd: begin
        if (c == 10'd0 || c == 10'd2) begin
          low_d = byte_i;
        end else if (c == 10'd1 || c == 10'd3) begin
          run.recs[n] = gmsp_pkg::mk_rec((c == 10'd1) ? gmsp_pkg::KindWidth
                                                      : gmsp_pkg::KindHeight,
                                         {4'd0, byte_i, low_q}, 1'b0);
          n = n + 1'b1;
        end else if (c == 10'd4) begin
          packed_d = byte_i;
          run.recs[0] = gmsp_pkg::mk_rec(gmsp_pkg::KindGctFlag,
                                         {19'd0, byte_i[7]}, 1'b0);
          run.recs[1] = gmsp_pkg::mk_rec(gmsp_pkg::KindColorRes,
                                         {16'd0, {1'b0, byte_i[6:4]} + 4'd1}, 1'b0);
          run.recs[2] = gmsp_pkg::mk_rec(gmsp_pkg::KindSortFlag,
                                         {19'd0, byte_i[3]}, 1'b0);
          run.recs[3] = gmsp_pkg::mk_rec(gmsp_pkg::KindGctSize,
                                         20'd2 << byte_i[2:0], 1'b0);
          n = 3'd4;
        end
        if (c >= 10'd6) begin
          if (packed_q[7]) begin
            phase_d = gmsp_pkg::PhGct;
            cnt_d   = gmsp_pkg::table_bytes(packed_q[2:0]);
          end else begin
            phase_d = gmsp_pkg::PhBlk;
            cnt_d   = '0;
          end
        end else begin
          cnt_d = c + 10'd1;
        end
      end
      gmsp_pkg::PhGct, gmsp_pkg::PhLct: begin
        cnt_d = (c == 10'd0) ? 10'd0 : c - 10'd1;
        if (cnt_d == 10'd0) begin
          phase_d = (phase_q == gmsp_pkg::PhGct) ? gmsp_pkg::PhBlk : gmsp_pkg::PhLzw;
        end
      end
      gmsp_pkg::PhBlk: begin
        cnt_d = '0;
        if (byte_i == gmsp_pkg::ByteTrailer) begin
          run.recs[n] = gmsp_pkg::mk_rec(gmsp_pkg::KindEnd, 20'd0, 1'b0);
          n = n + 1'b1;
          phase_d = gmsp_pkg::PhDoneEnd;
        end else if (byte_i == gmsp_pkg::ByteExtIntr) begin
          phase_d = gmsp_pkg::PhExt;
        end else if (byte_i == gmsp_pkg::ByteImgSep) begin
          phase_d = gmsp_pkg::PhImg;
        end
      end
      gmsp_pkg::PhImg: begin
        if (c >= 10'd8) begin
          packed_d = byte_i;
          if (byte_i[7]) begin
            phase_d = gmsp_pkg::PhLct;
            cnt_d   = gmsp_pkg::table_bytes(byte_i[2:0]);
          end else begin
            phase_d = gmsp_pkg::PhLzw;
            cnt_d   = '0;
          end
        end else begin
          cnt_d = c + 10'd1;
        end
      end
      gmsp_pkg::PhLzw: begin
        phase_d = gmsp_pkg::PhSubLen;
      end
      gmsp_pkg::PhSubLen: begin
        if (byte_i == 8'd0) begin
          phase_d = gmsp_pkg::PhBlk;
        end else begin
          sub_d   = byte_i;
          phase_d = gmsp_pkg::PhSubData;
        end
      end
      gmsp_pkg::PhSubData, gmsp_pkg::PhAppSkip: begin
        sub_d = (sub_q == 8'd0) ? 8'd0 : sub_q - 8'd1;
        if (sub_d == 8'd0) phase_d = gmsp_pkg::PhSubLen;
      end
      gmsp_pkg::PhExt: begin
        cnt_d = '0;
        if (byte_i == gmsp_pkg::LabelGce) begin
          phase_d = gmsp_pkg::PhGce;
        end else if (byte_i == gmsp_pkg::LabelCmt) begin
          started_d = 1'b0;
          phase_d   = gmsp_pkg::PhCmtLen;
        end else if (byte_i == gmsp_pkg::LabelApp) begin
          phase_d = gmsp_pkg::PhAppLen;
        end else begin
          phase_d = gmsp_pkg::PhSubLen;
        end
      end
      gmsp_pkg::PhGce: begin
        if (c == 10'd1) begin
          packed_d = byte_i;
        end else if (c == 10'd2) begin
          low_d = byte_i;
        end else if (c == 10'd3) begin
          if (d != 16'd0) begin
            run.recs[n] = gmsp_pkg::mk_rec(gmsp_pkg::KindDelayMs, dw, 1'b0);
            n = n + 1'b1;
          end
        end else if (c == 10'd4) begin
          if (packed_q[0]) begin
            run.recs[n] = gmsp_pkg::mk_rec(gmsp_pkg::KindTranspIdx,
                                           {12'd0, byte_i}, 1'b0);
            n = n + 1'b1;
          end
        end
        if (c >= 10'd5) begin
          phase_d = gmsp_pkg::PhBlk;
          cnt_d   = '0;
        end else begin
          cnt_d = c + 10'd1;
        end
      end
      gmsp_pkg::PhCmtLen: begin
        if (byte_i == 8'd0) begin
          phase_d = gmsp_pkg::PhBlk;
        end else begin
          sub_d   = byte_i;
          nul_d   = 1'b0;
          phase_d = gmsp_pkg::PhCmtData;
        end
      end
      gmsp_pkg::PhCmtData: begin
        if (byte_i == 8'd0) begin
          nul_d = 1'b1;
        end else if (!nul_q) begin
          run.recs[n] = gmsp_pkg::mk_rec(gmsp_pkg::KindCmtChar,
                                         {12'd0, byte_i}, !started_q);
          n = n + 1'b1;
          started_d = 1'b1;
        end
        sub_d = (sub_q == 8'd0) ? 8'd0 : sub_q - 8'd1;
        if (sub_d == 8'd0) phase_d = gmsp_pkg::PhCmtLen;
      end
      gmsp_pkg::PhAppLen: begin
        cnt_d = '0;
        if (byte_i == gmsp_pkg::AppIdLen) begin
          appm_d    = 1'b1;
          nul_d     = 1'b0;
          started_d = 1'b0;
          phase_d   = gmsp_pkg::PhAppId;
        end else if (byte_i == 8'd0) begin
          phase_d = gmsp_pkg::PhSubLen;
        end else begin
          sub_d   = byte_i;
          phase_d = gmsp_pkg::PhAppSkip;
        end
      end
      gmsp_pkg::PhAppId: begin
        if (byte_i != gmsp_pkg::netscape_char(ci)) appm_d = 1'b0;
        if (byte_i == 8'd0) begin
          nul_d = 1'b1;
        end else if (!nul_q) begin
          run.recs[n] = gmsp_pkg::mk_rec(gmsp_pkg::KindAppChar,
                                         {12'd0, byte_i}, !started_q);
          n = n + 1'b1;
          started_d = 1'b1;
        end
        if (ci >= 4'd10) begin
          phase_d = appm_d ? gmsp_pkg::PhNets : gmsp_pkg::PhSubLen;
          cnt_d   = '0;
        end else begin
          cnt_d = {6'd0, ci} + 10'd1;
        end
      end
      gmsp_pkg::PhNets: begin
        if (c == 10'd2) begin
          low_d = byte_i;
        end else if (c == 10'd3) begin
          run.recs[n] = gmsp_pkg::mk_rec(gmsp_pkg::KindLoopCnt,
                                         {4'd0, byte_i, low_q}, 1'b0);
          n = n + 1'b1;
        end
        if (c >= 10'd4) begin
          phase_d = gmsp_pkg::PhBlk;
          cnt_d   = '0;
        end else begin
          cnt_d = c + 10'd1;
        end
      end
      gmsp_pkg::PhDoneEnd: begin
      end
      default: begin
        phase_d = gmsp_pkg::PhDoneOpen;
      end
    endcase

    if (eoi_i) begin
      if (phase_d != gmsp_pkg::PhDoneEnd) begin
        run.recs[n] = gmsp_pkg::mk_rec(gmsp_pkg::KindEnd, 20'd0, 1'b0);
        n = n + 1'b1;
      end
      phase_d   = gmsp_pkg::PhHdr;
      cnt_d     = '0;
      sub_d     = '0;
      ver_d     = '0;
      packed_d  = '0;
      low_d     = '0;
      appm_d    = 1'b1;
      nul_d     = 1'b0;
      started_d = 1'b0;
      sigbad_d  = 1'b0;
    end

    run.cnt = n;
    run_o   = run;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= gmsp_pkg::PhHdr;
      cnt_q     <= '0;
      sub_q     <= '0;
      ver_q     <= '0;
      packed_q  <= '0;
      low_q     <= '0;
      appm_q    <= 1'b1;
      nul_q     <= 1'b0;
      started_q <= 1'b0;
      sigbad_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      sub_q     <= sub_d;
      ver_q     <= ver_d;
      packed_q  <= packed_d;
      low_q     <= low_d;
      appm_q    <= appm_d;
      nul_q     <= nul_d;
      started_q <= started_d;
      sigbad_q  <= sigbad_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/gmsp_run_buf.sv -----
// ----------------------------------------------------------------------------
// gmsp_run_buf
// Holds the records of one beat and presents them one per output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module gmsp_run_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire gmsp_pkg::run_t run_i,
  output logic                can_take_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output gmsp_pkg::rec_t      rec_o,
  output logic                last_o
);

  gmsp_pkg::rec_t [gmsp_pkg::MaxRecs-1:0] recs_q;
  logic [gmsp_pkg::CntW-1:0] cnt_q;
  logic [gmsp_pkg::CntW-1:0] idx_q;
  logic fire;

  assign out_valid_o = (cnt_q != '0);
  assign last_o      = (idx_q == cnt_q - 1'b1);
  assign rec_o       = recs_q[idx_q];
  assign fire        = out_valid_o && !out_stall_i;
  assign can_take_o  = !out_valid_o || (last_o && !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (load_i) recs_q <= run_i.recs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= run_i.cnt;
      idx_q <= '0;
    end else if (fire && last_o) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= idx_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/gif_metadata_stream_parser.sv -----
// ----------------------------------------------------------------------------
// gif_metadata_stream_parser
// Byte-stream GIF header/extension parser emitting metadata records.
// ----------------------------------------------------------------------------
// One file byte is taken per beat and parsed combinationally into a run of
// zero to seven records, held in an output run buffer. A byte is accepted
// while the buffer is empty or shows the last record of its run unstalled:
// a byte yielding several records, such as the header beat (six version
// records), keeps the input stalled while the run buffer drains, so ordinary
// image and table data moves at one byte per cycle unless a run is draining.
`default_nettype none

module gif_metadata_stream_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_input_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       record_kind_o,
  output logic [19:0]      record_value_o,
  output logic             first_of_string_o,
  output logic             last_of_run_o
);

  gmsp_pkg::run_t run;
  gmsp_pkg::rec_t rec;
  logic can_take;
  logic in_accept;
  logic load;

  assign in_stall_o = !can_take;
  assign in_accept  = in_valid_i && can_take;
  assign load       = in_accept && (run.cnt != '0);

  gmsp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (in_byte_i),
    .eoi_i    (end_of_input_i),
    .run_o    (run)
  );

  gmsp_run_buf u_run_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .run_i       (run),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rec_o       (rec),
    .last_o      (last_of_run_o)
  );

  assign record_kind_o     = rec.kind;
  assign record_value_o    = rec.value;
  assign first_of_string_o = rec.first;

  a_no_accept_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !(out_valid_o && !last_of_run_o))
    else $error("input beat accepted while a run is still draining");

  a_first_only_strings: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && first_of_string_o) |->
      (record_kind_o == gmsp_pkg::KindCmtChar || record_kind_o == gmsp_pkg::KindAppChar))
    else $error("first_of_string set on a non-string record");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_kind_o == gmsp_pkg::KindEnd) |-> last_of_run_o)
    else $error("end record not last in its run");

endmodule

`default_nettype wire
